// File: rtl/core/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg: shared types and constants for the triangle unit normal core
// Field widths, internal datapath widths and the item structs.
// ----------------------------------------------------------------------------
package tun_pkg;

   localparam int COORD_BITS     = 16;
   localparam int NORM_FRAC_BITS = 14;
   localparam int OUT_BITS       = 16;

   localparam int DIFF_W   = COORD_BITS + 1;
   localparam int NCROSS_W = 2 * DIFF_W;
   localparam int MAG_W    = 2 * DIFF_W - 1;
   localparam int HALF_W   = (MAG_W + 1) / 2;
   localparam int HIGH_W   = MAG_W - HALF_W;
   localparam int SUM_W    = 2 * MAG_W + 2;
   localparam int ROOT_W   = MAG_W + 1;
   localparam int TRIAL_W  = SUM_W + 1;
   localparam int QUO_W    = NORM_FRAC_BITS + 1;
   localparam int NUM_W    = MAG_W + NORM_FRAC_BITS;
   localparam int CMP_W    = ROOT_W + NORM_FRAC_BITS;
   localparam int EXT_W    = QUO_W + OUT_BITS;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] az;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by;
      logic signed [COORD_BITS-1:0] bz;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic signed [COORD_BITS-1:0] cz;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] norm_x;
      logic signed [OUT_BITS-1:0] norm_y;
      logic signed [OUT_BITS-1:0] norm_z;
      logic                       degenerate;
   } rsp_type;

   typedef logic [2:0][MAG_W-1:0] mag_vec_type;
   typedef logic [2:0][QUO_W-1:0] quo_vec_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] neg;
      logic       degen;
   } side_type;

endpackage

// File: rtl/core/tun_cross.sv
// ----------------------------------------------------------------------------
// tun_cross: edge vectors and cross product
// Three stages: edge differences, partial products, difference and magnitude.
// ----------------------------------------------------------------------------
module tun_cross import tun_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  req_type     in_item,
   output mag_vec_type out_mag,
   output side_type    out_side
);

   logic signed [COORD_BITS-1:0] a [3];
   logic signed [COORD_BITS-1:0] b [3];
   logic signed [COORD_BITS-1:0] c [3];
   logic signed [DIFF_W-1:0]     u_in [3];
   logic signed [DIFF_W-1:0]     v_in [3];
   logic signed [DIFF_W-1:0]     u_ff [3];
   logic signed [DIFF_W-1:0]     v_ff [3];
   logic signed [NCROSS_W-1:0]   p1_in [3];
   logic signed [NCROSS_W-1:0]   p2_in [3];
   logic signed [NCROSS_W-1:0]   p1_ff [3];
   logic signed [NCROSS_W-1:0]   p2_ff [3];
   logic signed [NCROSS_W-1:0]   n [3];
   logic [NCROSS_W-1:0]          absn [3];
   mag_vec_type                  mag_in;
   mag_vec_type                  mag_ff;
   logic [2:0]                   neg_in;
   logic [2:0]                   neg_ff;
   logic                         v1_ff;
   logic                         v2_ff;
   logic                         v3_ff;

   always_comb begin
      a[0] = in_item.ax; a[1] = in_item.ay; a[2] = in_item.az;
      b[0] = in_item.bx; b[1] = in_item.by; b[2] = in_item.bz;
      c[0] = in_item.cx; c[1] = in_item.cy; c[2] = in_item.cz;
      for (int k = 0; k < 3; k++) begin
         u_in[k] = DIFF_W'(b[k]) - DIFF_W'(a[k]);
         v_in[k] = DIFF_W'(c[k]) - DIFF_W'(a[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         p1_in[k] = NCROSS_W'(u_ff[(k + 1) % 3]) * NCROSS_W'(v_ff[(k + 2) % 3]);
         p2_in[k] = NCROSS_W'(u_ff[(k + 2) % 3]) * NCROSS_W'(v_ff[(k + 1) % 3]);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         n[k]      = p1_ff[k] - p2_ff[k];
         neg_in[k] = n[k][NCROSS_W-1];
         absn[k]   = neg_in[k] ? NCROSS_W'(-n[k]) : NCROSS_W'(n[k]);
         mag_in[k] = absn[k][MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff   <= u_in;
         v_ff   <= v_in;
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   assign out_mag        = mag_ff;
   assign out_side.valid = v3_ff;
   assign out_side.neg   = neg_ff;
   assign out_side.degen = 1'b0;

endmodule

// File: rtl/core/tun_sumsq.sv
// ----------------------------------------------------------------------------
// tun_sumsq: sum of squares of the cross product magnitudes
// Three stages: split partial products, squares, three-way sum.
// ----------------------------------------------------------------------------
module tun_sumsq import tun_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  mag_vec_type      in_mag,
   input  side_type         in_side,
   output logic [SUM_W-1:0] out_sum,
   output mag_vec_type      out_mag,
   output side_type         out_side
);

   logic [2*HIGH_W-1:0]   hh_ff [3];
   logic [MAG_W-1:0]      hl_ff [3];
   logic [2*HALF_W-1:0]   ll_ff [3];
   logic [SUM_W-1:0]      sq_in [3];
   logic [SUM_W-1:0]      sq_ff [3];
   logic [SUM_W-1:0]      sum_in;
   logic [SUM_W-1:0]      sum_ff;
   mag_vec_type           mag1_ff;
   mag_vec_type           mag2_ff;
   mag_vec_type           mag3_ff;
   side_type              side_in;
   side_type              side1_ff;
   side_type              side2_ff;
   side_type              side3_ff;

   always_comb begin
      side_in       = in_side;
      side_in.degen = (in_mag == '0);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = (SUM_W'(hh_ff[k]) << (2 * HALF_W))
                  + (SUM_W'(hl_ff[k]) << (HALF_W + 1))
                  + SUM_W'(ll_ff[k]);
      end
      sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff.valid <= 1'b0;
         side2_ff.valid <= 1'b0;
         side3_ff.valid <= 1'b0;
      end else if (adv) begin
         side1_ff.valid <= side_in.valid;
         side2_ff.valid <= side1_ff.valid;
         side3_ff.valid <= side2_ff.valid;
      end
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            hh_ff[k] <= (2*HIGH_W)'(in_mag[k][MAG_W-1:HALF_W])
                      * (2*HIGH_W)'(in_mag[k][MAG_W-1:HALF_W]);
            hl_ff[k] <= MAG_W'(in_mag[k][MAG_W-1:HALF_W]) * MAG_W'(in_mag[k][HALF_W-1:0]);
            ll_ff[k] <= (2*HALF_W)'(in_mag[k][HALF_W-1:0])
                      * (2*HALF_W)'(in_mag[k][HALF_W-1:0]);
         end
         sq_ff          <= sq_in;
         sum_ff         <= sum_in;
         mag1_ff        <= in_mag;
         mag2_ff        <= mag1_ff;
         mag3_ff        <= mag2_ff;
         side1_ff.neg   <= side_in.neg;
         side1_ff.degen <= side_in.degen;
         side2_ff.neg   <= side1_ff.neg;
         side2_ff.degen <= side1_ff.degen;
         side3_ff.neg   <= side2_ff.neg;
         side3_ff.degen <= side2_ff.degen;
      end
   end

   assign out_sum  = sum_ff;
   assign out_mag  = mag3_ff;
   assign out_side = side3_ff;

endmodule

// File: rtl/core/tun_isqrt.sv
// ----------------------------------------------------------------------------
// tun_isqrt: pipelined integer square root
// One root bit per stage, most significant first, restoring method.
// ----------------------------------------------------------------------------
module tun_isqrt import tun_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic [SUM_W-1:0]  in_sum,
   input  mag_vec_type       in_mag,
   input  side_type          in_side,
   output logic [ROOT_W-1:0] out_root,
   output mag_vec_type       out_mag,
   output side_type          out_side
);

   logic [SUM_W-1:0]  rem_w  [0:ROOT_W];
   logic [ROOT_W-1:0] root_w [0:ROOT_W];
   mag_vec_type       mag_w  [0:ROOT_W];
   side_type          side_w [0:ROOT_W];

   assign rem_w[0]  = in_sum;
   assign root_w[0] = '0;
   assign mag_w[0]  = in_mag;
   assign side_w[0] = in_side;

   for (genvar s = 0; s < ROOT_W; s++) begin : g_step
      localparam int BIT = ROOT_W - 1 - s;
      logic [TRIAL_W-1:0] trial;
      logic               take;
      logic [SUM_W-1:0]   rem_in;
      logic [ROOT_W-1:0]  root_in;
      logic [SUM_W-1:0]   rem_ff;
      logic [ROOT_W-1:0]  root_ff;
      mag_vec_type        mag_ff;
      side_type           side_ff;

      assign trial   = (TRIAL_W'(root_w[s]) << (BIT + 1)) | (TRIAL_W'(1) << (2 * BIT));
      assign take    = TRIAL_W'(rem_w[s]) >= trial;
      assign rem_in  = take ? SUM_W'(TRIAL_W'(rem_w[s]) - trial) : rem_w[s];
      assign root_in = take ? (root_w[s] | (ROOT_W'(1) << BIT)) : root_w[s];

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff.valid <= 1'b0;
         end else if (adv) begin
            side_ff.valid <= side_w[s].valid;
         end
         if (adv) begin
            rem_ff        <= rem_in;
            root_ff       <= root_in;
            mag_ff        <= mag_w[s];
            side_ff.neg   <= side_w[s].neg;
            side_ff.degen <= side_w[s].degen;
         end
      end

      assign rem_w[s+1]  = rem_ff;
      assign root_w[s+1] = root_ff;
      assign mag_w[s+1]  = mag_ff;
      assign side_w[s+1] = side_ff;
   end

   assign out_root = root_w[ROOT_W];
   assign out_mag  = mag_w[ROOT_W];
   assign out_side = side_w[ROOT_W];

endmodule

// File: rtl/core/tun_divide.sv
// ----------------------------------------------------------------------------
// tun_divide: pipelined division of the three magnitudes by the root
// One quotient bit per stage for all three components in parallel.
// ----------------------------------------------------------------------------
module tun_divide import tun_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic [ROOT_W-1:0] in_root,
   input  mag_vec_type       in_mag,
   input  side_type          in_side,
   output quo_vec_type       out_quo,
   output side_type          out_side
);

   logic [2:0][NUM_W-1:0] rem_w  [0:QUO_W];
   quo_vec_type           quo_w  [0:QUO_W];
   logic [ROOT_W-1:0]     root_w [0:QUO_W];
   side_type              side_w [0:QUO_W];

   for (genvar k = 0; k < 3; k++) begin : g_init
      assign rem_w[0][k] = NUM_W'(in_mag[k]) << NORM_FRAC_BITS;
   end
   assign quo_w[0]  = '0;
   assign root_w[0] = in_root;
   assign side_w[0] = in_side;

   for (genvar s = 0; s < QUO_W; s++) begin : g_step
      localparam int BIT = NORM_FRAC_BITS - s;
      logic [CMP_W-1:0]      dsh;
      logic [2:0][NUM_W-1:0] rem_in;
      quo_vec_type           quo_in;
      logic [2:0][NUM_W-1:0] rem_ff;
      quo_vec_type           quo_ff;
      logic [ROOT_W-1:0]     root_ff;
      side_type              side_ff;

      assign dsh = CMP_W'(root_w[s]) << BIT;

      always_comb begin
         for (int k = 0; k < 3; k++) begin
            if (CMP_W'(rem_w[s][k]) >= dsh) begin
               rem_in[k] = NUM_W'(CMP_W'(rem_w[s][k]) - dsh);
               quo_in[k] = quo_w[s][k] | (QUO_W'(1) << BIT);
            end else begin
               rem_in[k] = rem_w[s][k];
               quo_in[k] = quo_w[s][k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff.valid <= 1'b0;
         end else if (adv) begin
            side_ff.valid <= side_w[s].valid;
         end
         if (adv) begin
            rem_ff        <= rem_in;
            quo_ff        <= quo_in;
            root_ff       <= root_w[s];
            side_ff.neg   <= side_w[s].neg;
            side_ff.degen <= side_w[s].degen;
         end
      end

      assign rem_w[s+1]  = rem_ff;
      assign quo_w[s+1]  = quo_ff;
      assign root_w[s+1] = root_ff;
      assign side_w[s+1] = side_ff;
   end

   assign out_quo  = quo_w[QUO_W];
   assign out_side = side_w[QUO_W];

endmodule

// File: rtl/core/triangle_unit_normal_core.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal_core: unit surface normal of one triangle per item
// Cross product of the edge vectors, divided by its integer length.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: req_valid, req_stall, req (three Q8.8 vertices).
//   rsp channel: rsp_valid, rsp_stall, rsp (Q1.14 normal and degenerate flag).
//   An item moves on a clock edge with valid high and stall low.
//   From request to response an item passes 3 cross product stages,
//   3 sum of squares stages, 34 square root stages (one root bit each),
//   15 divide stages (one quotient bit each) and the output register.
//   Throughput is one triangle per cycle unless a stalled response holds the
//   pipeline; every stage is a register. A degenerate triangle returns a zero
//   normal with degenerate set. Reset clears every valid bit; the pipeline
//   comes out empty and ready. When rsp_stall is high with a response pending,
//   the whole pipeline holds and req_stall rises in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module triangle_unit_normal_core import tun_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   logic              adv;
   mag_vec_type       cr_mag;
   side_type          cr_side;
   logic [SUM_W-1:0]  sq_sum;
   mag_vec_type       sq_mag;
   side_type          sq_side;
   logic [ROOT_W-1:0] rt_root;
   mag_vec_type       rt_mag;
   side_type          rt_side;
   quo_vec_type       dv_quo;
   side_type          dv_side;
   logic [EXT_W-1:0]  ext [3];
   logic [OUT_BITS-1:0] comp [3];
   rsp_type           rsp_in;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   tun_cross u_cross (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .in_item  (req),
      .out_mag  (cr_mag),
      .out_side (cr_side)
   );

   tun_sumsq u_sumsq (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_mag   (cr_mag),
      .in_side  (cr_side),
      .out_sum  (sq_sum),
      .out_mag  (sq_mag),
      .out_side (sq_side)
   );

   tun_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_sum   (sq_sum),
      .in_mag   (sq_mag),
      .in_side  (sq_side),
      .out_root (rt_root),
      .out_mag  (rt_mag),
      .out_side (rt_side)
   );

   tun_divide u_divide (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_root  (rt_root),
      .in_mag   (rt_mag),
      .in_side  (rt_side),
      .out_quo  (dv_quo),
      .out_side (dv_side)
   );

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ext[k]  = dv_side.neg[k] ? EXT_W'(-EXT_W'(dv_quo[k])) : EXT_W'(dv_quo[k]);
         comp[k] = dv_side.degen ? '0 : ext[k][OUT_BITS-1:0];
      end
      rsp_in.norm_x     = comp[0];
      rsp_in.norm_y     = comp[1];
      rsp_in.norm_z     = comp[2];
      rsp_in.degenerate = dv_side.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef NO_ASSERTIONS
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.degenerate |->
         rsp.norm_x == '0 && rsp.norm_y == '0 && rsp.norm_z == '0)
      else $error("degenerate response with nonzero normal");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked response");

   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled response changed");
`endif

endmodule
